>>> hdl/bgi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bgi_pkg
// Shared codes, constants and a saturation helper of the bilinear grid interpolator.
// ----------------------------------------------------------------------------
package bgi_pkg;

  localparam int unsigned RowDepthDef = 128;
  localparam int unsigned ColDepthDef = 128;
  localparam int unsigned FracBitsDef = 16;

  // item kinds
  localparam logic [1:0] KindTable  = 2'd0;
  localparam logic [1:0] KindRadial = 2'd1;
  localparam logic [1:0] KindCosine = 2'd2;
  localparam logic [1:0] KindQuery  = 2'd3;

  // register indexes
  localparam logic [1:0] RegRowCount = 2'd0;
  localparam logic [1:0] RegColCount = 2'd1;
  localparam logic [1:0] RegRadStep  = 2'd2;
  localparam logic [1:0] RegCosStep  = 2'd3;

  // saturate a 66-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) sat32 = 32'sh7fffffff;
    else if (v < lo) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

endpackage
`default_nettype wire

>>> hdl/bgi_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bgi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bgi_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> hdl/bgi_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bgi_divider
// Pipelined signed floor division, one quotient bit per stage, with a
// side payload carried along. Quotient saturated to 32 bits inside the block.
// ----------------------------------------------------------------------------
module bgi_divider #(
  parameter int unsigned NumW  = 66,
  parameter int unsigned DenW  = 33,
  parameter int unsigned QW    = 34,
  parameter int unsigned SideW = 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire logic signed [NumW-1:0]  num_i,
  input  wire logic signed [DenW-1:0]  den_i,
  input  wire logic [SideW-1:0]        side_i,
  output logic                         valid_o,
  output logic signed [31:0]           quo_o,
  output logic [SideW-1:0]             side_o
);
  // unsigned magnitude long division; quotient limited to QW bits (saturates
  // well before that width matters since outputs are clamped to 32 bits)
  typedef struct packed {
    logic [NumW-1:0]   rem;
    logic [DenW-1:0]   den;
    logic [QW-1:0]     quo;
    logic              neg;
    logic              big;
    logic [SideW-1:0]  side;
  } stage_t;

  stage_t st_q [QW+1];
  stage_t st_d [QW+1];
  logic [QW:0] vld_q;

  logic [NumW-1:0]  nmag;
  logic [DenW-1:0]  dmag;
  logic [NumW+QW:0] ovf_lim;
  logic [NumW+QW:0] trial;

  // operand magnitudes, overflow check, then one trial subtract per stage
  always_comb begin
    nmag = num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);
    dmag = den_i[DenW-1] ? DenW'(-den_i) : DenW'(den_i);
    ovf_lim = (NumW+QW+1)'(dmag) << QW;
    st_d[0].rem  = nmag;
    st_d[0].den  = dmag;
    st_d[0].quo  = '0;
    st_d[0].neg  = num_i[NumW-1] ^ den_i[DenW-1];
    st_d[0].big  = ((NumW+QW+1)'(nmag) >= ovf_lim);
    st_d[0].side = side_i;
    trial = '0;
    for (int k = 0; k < QW; k++) begin
      st_d[k+1] = st_q[k];
      trial = (NumW+QW+1)'(st_q[k].den) << (QW - 1 - k);
      if ((NumW+QW+1)'(st_q[k].rem) >= trial) begin
        st_d[k+1].rem = st_q[k].rem - NumW'(trial);
        st_d[k+1].quo[QW-1-k] = 1'b1;
      end
    end
  end

  // valid bits travel beside the stage data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= QW; k++) st_q[k] <= st_d[k];
    end
  end

  // sign fix with floor rounding, then clamp
  logic signed [QW+1:0] qs;
  always_comb begin
    if (st_q[QW].neg)
      qs = -$signed({2'b00, st_q[QW].quo}) - $signed((QW+2)'(st_q[QW].rem != '0));
    else
      qs = $signed({2'b00, st_q[QW].quo});
    if (st_q[QW].big)
      quo_o = st_q[QW].neg ? 32'sh80000000 : 32'sh7fffffff;
    else
      quo_o = bgi_pkg::sat32(66'(qs));
    valid_o = vld_q[QW];
    side_o  = st_q[QW].side;
  end
endmodule
`default_nettype wire

>>> hdl/bilinear_grid_interpolator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_grid_interpolator
// Bilinear lookup over a radial by cosine table of signed Q15.16 values.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid_i / in_stall_o) carries one item per cycle when
//  not stalled: a table write, a grid point write, or a query. Writes give
//  no result; a query gives one item on the output (out_valid_o / out_stall_i).
//  Configuration writes (cfg_valid_i / cfg_ready_o, always ready) set the
//  grid counts and nominal steps. The user must make them only while the
//  block is idle; the block does not enforce it. Throughput: one item per
//  cycle unless stalled. A query passes, in order, offset, two index stages,
//  grid read, numerators, the two fraction dividers (35 stages), corner
//  read, three blend stages. Writes ride a delay line and land where
//  queries read, so each query sees exactly the writes accepted before it.
//  All stages move together: while out_stall_i holds a result the whole
//  pipe freezes and in_stall_o rises, so nothing is lost or repeated.
//  Reset clears the valid bits, the write delay line and the configuration
//  registers; tables are undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
module bilinear_grid_interpolator #(
  parameter int unsigned ROW_DEPTH = bgi_pkg::RowDepthDef,
  parameter int unsigned COL_DEPTH = bgi_pkg::ColDepthDef,
  parameter int unsigned FRAC_BITS = bgi_pkg::FracBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         kind_i,
  input  wire logic [6:0]         row_index_i,
  input  wire logic [6:0]         col_index_i,
  input  wire logic signed [31:0] write_value_i,
  input  wire logic signed [31:0] query_radius_i,
  input  wire logic signed [31:0] query_cosine_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      interp_value_o,
  output logic                    cell_degenerate_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);
  localparam int unsigned RW = $clog2(ROW_DEPTH);
  localparam int unsigned CW = $clog2(COL_DEPTH);
  localparam int unsigned TW = RW + CW;
  localparam int unsigned QW = 34;
  // delay-line taps: grid writes land at the grid read, table writes at the
  // corner read
  localparam int unsigned GridTap = 2;
  localparam int unsigned TabTap  = 5 + QW;

  // ---------------- configuration ----------------
  logic [7:0]  row_count_q, col_count_q;
  logic [30:0] rad_step_q, cos_step_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= 8'd2;
      col_count_q <= 8'd2;
      rad_step_q  <= 31'd65536;
      cos_step_q  <= 31'd65536;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bgi_pkg::RegRowCount: row_count_q <= cfg_data_i[7:0];
        bgi_pkg::RegColCount: col_count_q <= cfg_data_i[7:0];
        bgi_pkg::RegRadStep:  rad_step_q  <= cfg_data_i[30:0];
        bgi_pkg::RegCosStep:  cos_step_q  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // effective max cell index (count-2), clamped
  logic [10:0] rmax, cmax;
  always_comb begin
    if (row_count_q < 8'd2) rmax = '0;
    else if (11'(row_count_q) > 11'(ROW_DEPTH)) rmax = 11'(ROW_DEPTH - 2);
    else rmax = 11'(row_count_q) - 11'd2;
    if (col_count_q < 8'd2) cmax = '0;
    else if (11'(col_count_q) > 11'(COL_DEPTH)) cmax = 11'(COL_DEPTH - 2);
    else cmax = 11'(col_count_q) - 11'd2;
  end

  // global advance: whole pipe moves unless output holds a stalled result
  logic en;
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  logic acc;
  assign acc = in_valid_i && en;

  // ---------------- writes ----------------
  typedef struct packed {
    logic               tab;
    logic               rad;
    logic               cos;
    logic [6:0]         row;
    logic [6:0]         col;
    logic signed [31:0] val;
  } wr_item_t;

  logic in_tab, in_rad, in_cos;
  assign in_tab = acc && kind_i == bgi_pkg::KindTable
                  && 32'(row_index_i) < ROW_DEPTH && 32'(col_index_i) < COL_DEPTH;
  assign in_rad = acc && kind_i == bgi_pkg::KindRadial && 32'(row_index_i) < ROW_DEPTH;
  assign in_cos = acc && kind_i == bgi_pkg::KindCosine && 32'(col_index_i) < COL_DEPTH;

  wr_item_t wr_d;
  wr_item_t wr_q [TabTap+1];
  always_comb begin
    wr_d.tab = in_tab;
    wr_d.rad = in_rad;
    wr_d.cos = in_cos;
    wr_d.row = row_index_i;
    wr_d.col = col_index_i;
    wr_d.val = write_value_i;
  end

  // write delay line, moves with the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= TabTap; i++) wr_q[i] <= '0;
    end else if (en) begin
      wr_q[0] <= wr_d;
      for (int i = 1; i <= TabTap; i++) wr_q[i] <= wr_q[i-1];
    end
  end

  logic tab_we, rad_we, cos_we;
  logic [TW-1:0] tab_wa;
  assign rad_we = en && wr_q[GridTap].rad;
  assign cos_we = en && wr_q[GridTap].cos;
  assign tab_we = en && wr_q[TabTap].tab;
  assign tab_wa = {RW'(wr_q[TabTap].row), CW'(wr_q[TabTap].col)};

  // grid[0] shadows, updated at acceptance so the offset stage sees them in order
  logic signed [31:0] rad0_q, cos0_q;
  always_ff @(posedge clk_i) begin
    if (in_rad && row_index_i == 7'd0) rad0_q <= write_value_i;
    if (in_cos && col_index_i == 7'd0) cos0_q <= write_value_i;
  end

  // ---------------- S1: offsets ----------------
  logic s1_v_q;
  logic signed [32:0] s1_dr_q, s1_dc_q;
  logic signed [31:0] s1_r_q, s1_c_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (en) s1_v_q <= acc && kind_i == bgi_pkg::KindQuery;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_dr_q <= 33'(query_radius_i) - 33'(rad0_q);
      s1_dc_q <= 33'(query_cosine_i) - 33'(cos0_q);
      s1_r_q  <= query_radius_i;
      s1_c_q  <= query_cosine_i;
    end
  end

  // ---------------- S2: cell index ----------------
  // The quotient only matters up to the clamp (< 1024); compare against
  // step multiples via a small index search would be long, so use a
  // short per-axis reciprocal-free compare: idx = min(diff/step, max).
  // Done as an 11-step restoring division over two stages.
  typedef struct packed {
    logic [32:0] rem;
    logic [10:0] q;
    logic        over;
  } idiv_t;

  function automatic idiv_t idiv_init(input logic signed [32:0] d, input logic [30:0] s);
    idiv_t o;
    o.rem  = d[32] ? '0 : d;
    o.q    = '0;
    o.over = (s != '0) && !d[32] && (44'(d) >= (44'(s) << 11));
    return o;
  endfunction

  function automatic idiv_t idiv_step(input idiv_t i, input logic [30:0] s,
                                      input int unsigned lo, input int unsigned hi);
    idiv_t o;
    logic [43:0] t;
    o = i;
    for (int k = 10; k >= 0; k--) begin
      t = 44'(s) << k;
      if (k >= int'(lo) && k <= int'(hi) && s != '0 && 44'(o.rem) >= t) begin
        o.rem = o.rem - 33'(t);
        o.q[k] = 1'b1;
      end
    end
    return o;
  endfunction

  logic s2_v_q;
  idiv_t s2_ir_q, s2_ic_q;
  logic signed [31:0] s2_r_q, s2_c_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (en) s2_v_q <= s1_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_ir_q <= idiv_step(idiv_init(s1_dr_q, rad_step_q), rad_step_q, 6, 10);
      s2_ic_q <= idiv_step(idiv_init(s1_dc_q, cos_step_q), cos_step_q, 6, 10);
      s2_r_q  <= s1_r_q;
      s2_c_q  <= s1_c_q;
    end
  end

  logic s3_v_q;
  idiv_t s3_ir_q, s3_ic_q;
  logic signed [31:0] s3_r_q, s3_c_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else if (en) s3_v_q <= s2_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_ir_q <= idiv_step(s2_ir_q, rad_step_q, 0, 5);
      s3_ic_q <= idiv_step(s2_ic_q, cos_step_q, 0, 5);
      s3_r_q  <= s2_r_q;
      s3_c_q  <= s2_c_q;
    end
  end

  // clamp and issue grid reads
  logic [RW-1:0] ir;
  logic [CW-1:0] ic;
  always_comb begin
    ir = (s3_ir_q.over || s3_ir_q.q > rmax) ? RW'(rmax) : RW'(s3_ir_q.q);
    ic = (s3_ic_q.over || s3_ic_q.q > cmax) ? CW'(cmax) : CW'(s3_ic_q.q);
  end

  // ---------------- S4: grid reads (two copies give g[i], g[i+1]) -----
  logic signed [31:0] r1, r2, c1, c2;
  bgi_ram #(.Width(32), .Depth(ROW_DEPTH)) u_rad_a (
    .clk_i, .we_i(rad_we), .waddr_i(RW'(wr_q[GridTap].row)),
    .wdata_i(wr_q[GridTap].val), .re_i(en), .raddr_i(ir), .rdata_o(r1));
  bgi_ram #(.Width(32), .Depth(ROW_DEPTH)) u_rad_b (
    .clk_i, .we_i(rad_we), .waddr_i(RW'(wr_q[GridTap].row)),
    .wdata_i(wr_q[GridTap].val), .re_i(en), .raddr_i(RW'(ir + RW'(1))), .rdata_o(r2));
  bgi_ram #(.Width(32), .Depth(COL_DEPTH)) u_cos_a (
    .clk_i, .we_i(cos_we), .waddr_i(CW'(wr_q[GridTap].col)),
    .wdata_i(wr_q[GridTap].val), .re_i(en), .raddr_i(ic), .rdata_o(c1));
  bgi_ram #(.Width(32), .Depth(COL_DEPTH)) u_cos_b (
    .clk_i, .we_i(cos_we), .waddr_i(CW'(wr_q[GridTap].col)),
    .wdata_i(wr_q[GridTap].val), .re_i(en), .raddr_i(CW'(ic + CW'(1))), .rdata_o(c2));

  logic s4_v_q;
  logic [RW-1:0] s4_ir_q;
  logic [CW-1:0] s4_ic_q;
  logic signed [31:0] s4_r_q, s4_c_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else if (en) s4_v_q <= s3_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_ir_q <= ir;
      s4_ic_q <= ic;
      s4_r_q  <= s3_r_q;
      s4_c_q  <= s3_c_q;
    end
  end

  // ---------------- S5: numerators and widths ----------------
  localparam int unsigned NumW = 34 + FRAC_BITS;
  logic s5_v_q, s5_deg_q;
  logic signed [NumW-1:0] s5_nr_q, s5_nc_q;
  logic signed [32:0] s5_wr_q, s5_wc_q;
  logic [TW-1:0] s5_ta_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_v_q <= 1'b0;
    else if (en) s5_v_q <= s4_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_wr_q  <= 33'(r2) - 33'(r1);
      s5_wc_q  <= 33'(c2) - 33'(c1);
      s5_deg_q <= (r2 == r1) || (c2 == c1);
      s5_nr_q  <= NumW'(33'(s4_r_q) - 33'(r1)) <<< FRAC_BITS;
      s5_nc_q  <= NumW'(33'(s4_c_q) - 33'(c1)) <<< FRAC_BITS;
      s5_ta_q  <= {s4_ir_q, s4_ic_q};
    end
  end

  // ---------------- fraction dividers ----------------
  logic dv_v, dv_deg, dv_unused;
  logic signed [31:0] fr, fc;
  logic [TW:0] dv_side, dc_side;
  logic dc_v;
  bgi_divider #(.NumW(NumW), .DenW(33), .QW(QW), .SideW(TW+1)) u_div_r (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s5_v_q), .num_i(s5_nr_q),
    .den_i(s5_deg_q ? 33'sd1 : s5_wr_q), .side_i({s5_deg_q, s5_ta_q}),
    .valid_o(dv_v), .quo_o(fr), .side_o(dv_side));
  bgi_divider #(.NumW(NumW), .DenW(33), .QW(QW), .SideW(TW+1)) u_div_c (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s5_v_q), .num_i(s5_nc_q),
    .den_i(s5_deg_q ? 33'sd1 : s5_wc_q), .side_i({s5_deg_q, s5_ta_q}),
    .valid_o(dc_v), .quo_o(fc), .side_o(dc_side));
  assign dv_deg = dv_side[TW];
  assign dv_unused = dc_v ^ dc_side[0];

  // corner reads: four table copies, one per corner
  logic [RW-1:0] tr;
  logic [CW-1:0] tc;
  assign tr = dv_side[TW-1:CW];
  assign tc = dv_side[CW-1:0];
  logic signed [31:0] y00, y01, y10, y11;
  bgi_ram #(.Width(32), .Depth(ROW_DEPTH*COL_DEPTH)) u_t00 (
    .clk_i, .we_i(tab_we), .waddr_i(tab_wa), .wdata_i(wr_q[TabTap].val),
    .re_i(en), .raddr_i({tr, tc}), .rdata_o(y00));
  bgi_ram #(.Width(32), .Depth(ROW_DEPTH*COL_DEPTH)) u_t01 (
    .clk_i, .we_i(tab_we), .waddr_i(tab_wa), .wdata_i(wr_q[TabTap].val),
    .re_i(en), .raddr_i({tr, CW'(tc + CW'(1))}), .rdata_o(y01));
  bgi_ram #(.Width(32), .Depth(ROW_DEPTH*COL_DEPTH)) u_t10 (
    .clk_i, .we_i(tab_we), .waddr_i(tab_wa), .wdata_i(wr_q[TabTap].val),
    .re_i(en), .raddr_i({RW'(tr + RW'(1)), tc}), .rdata_o(y10));
  bgi_ram #(.Width(32), .Depth(ROW_DEPTH*COL_DEPTH)) u_t11 (
    .clk_i, .we_i(tab_we), .waddr_i(tab_wa), .wdata_i(wr_q[TabTap].val),
    .re_i(en), .raddr_i({RW'(tr + RW'(1)), CW'(tc + CW'(1))}), .rdata_o(y11));

  logic s6_v_q, s6_deg_q;
  logic signed [31:0] s6_fr_q, s6_fc_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s6_v_q <= 1'b0;
    else if (en) s6_v_q <= dv_v;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_deg_q <= dv_deg | dv_unused & 1'b0;
      s6_fr_q  <= fr;
      s6_fc_q  <= fc;
    end
  end

  // ---------------- S7: column products ----------------
  logic s7_v_q, s7_deg_q;
  logic signed [65:0] s7_pa_q, s7_pb_q;
  logic signed [31:0] s7_y00_q, s7_y10_q, s7_fr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s7_v_q <= 1'b0;
    else if (en) s7_v_q <= s6_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_pa_q  <= 66'(s6_fc_q) * 66'(33'(y01) - 33'(y00));
      s7_pb_q  <= 66'(s6_fc_q) * 66'(33'(y11) - 33'(y10));
      s7_y00_q <= y00;
      s7_y10_q <= y10;
      s7_fr_q  <= s6_fr_q;
      s7_deg_q <= s6_deg_q;
    end
  end

  // ---------------- S8: a and b ----------------
  logic s8_v_q, s8_deg_q;
  logic signed [31:0] s8_a_q, s8_b_q, s8_fr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s8_v_q <= 1'b0;
    else if (en) s8_v_q <= s7_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_a_q   <= bgi_pkg::sat32(66'(s7_y00_q) + (s7_pa_q >>> FRAC_BITS));
      s8_b_q   <= bgi_pkg::sat32(66'(s7_y10_q) + (s7_pb_q >>> FRAC_BITS));
      s8_fr_q  <= s7_fr_q;
      s8_deg_q <= s7_deg_q;
    end
  end

  // ---------------- S9: row product ----------------
  logic s9_v_q, s9_deg_q;
  logic signed [65:0] s9_p_q;
  logic signed [31:0] s9_a_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s9_v_q <= 1'b0;
    else if (en) s9_v_q <= s8_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s9_p_q   <= 66'(s8_fr_q) * 66'(33'(s8_b_q) - 33'(s8_a_q));
      s9_a_q   <= s8_a_q;
      s9_deg_q <= s8_deg_q;
    end
  end

  // ---------------- output register ----------------
  logic out_v_q, out_deg_q;
  logic signed [31:0] out_val_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= s9_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_deg_q <= s9_deg_q;
      out_val_q <= s9_deg_q ? 32'sd0
                 : bgi_pkg::sat32(66'(s9_a_q) + (s9_p_q >>> FRAC_BITS));
    end
  end
  assign out_valid_o       = out_v_q;
  assign interp_value_o    = out_val_q;
  assign cell_degenerate_o = out_deg_q;

`ifndef SYNTH
  // a held result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(interp_value_o))
    else $error("result changed while stalled");
  // input stalled exactly when output held
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("stall mismatch");
  // degenerate cells give zero
  a_deg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cell_degenerate_o |-> interp_value_o == 32'sd0)
    else $error("degenerate nonzero");
`endif
endmodule
`default_nettype wire
